// ----- rtl/cartridge_bank_irq_mapper_defines.svh -----
// Assertion macros shared by the mapper checker.
`ifndef CARTRIDGE_BANK_IRQ_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_IRQ_MAPPER_DEFINES_SVH

// Clocked assertion, quiet while reset is high.
`define CBIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also checks the cycles around reset.
`define CBIM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/cbim_pkg.sv -----
package cbim_pkg;

  // Field widths
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LINE_W  = 9;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned COUNT_W = 16;

  // Default number of visible scanlines
  localparam int unsigned VISIBLE_LINES_DEF = 240;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Register map
  localparam logic [ADDR_W-1:0] ADR_MIRROR_SINGLE = 16'h42FE;
  localparam logic [ADDR_W-1:0] ADR_MIRROR_VH     = 16'h42FF;
  localparam logic [ADDR_W-1:0] ADR_IRQ_OFF       = 16'h4501;
  localparam logic [ADDR_W-1:0] ADR_LATCH_LO      = 16'h4502;
  localparam logic [ADDR_W-1:0] ADR_LATCH_HI      = 16'h4503;
  localparam logic [ADDR_W-1:0] ADR_PRG_BASE      = 16'h4504;
  localparam logic [ADDR_W-1:0] ADR_PRG_LAST      = 16'h4507;
  localparam logic [ADDR_W-1:0] ADR_CHR_BASE      = 16'h4510;
  localparam logic [ADDR_W-1:0] ADR_CHR_LAST      = 16'h4517;

  // Data bit that picks the mirroring mode
  localparam int unsigned MIRROR_BIT_POS = 4;

  // Scanline counter
  localparam logic [COUNT_W-1:0] COUNT_STEP = 16'd113;
  localparam logic [COUNT_W-1:0] FIRE_LEVEL = 16'hFFFF - COUNT_STEP;

  typedef enum logic [1:0] {
    UPD_NONE   = 2'd0,
    UPD_PRG    = 2'd1,
    UPD_CHR    = 2'd2,
    UPD_MIRROR = 2'd3
  } update_kind_t;

  typedef enum logic [1:0] {
    MIR_SINGLE_A   = 2'd0,
    MIR_SINGLE_B   = 2'd1,
    MIR_VERTICAL   = 2'd2,
    MIR_HORIZONTAL = 2'd3
  } mirror_t;

endpackage

// ----- rtl/cbim_if.sv -----
interface cbim_req_if import cbim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic [LINE_W-1:0] line_number;
  logic              rendering_on;

  modport source (output valid, kind, address, write_data, line_number, rendering_on,
                  input ready);
  modport sink (input valid, kind, address, write_data, line_number, rendering_on,
                output ready);
endinterface

interface cbim_rsp_if import cbim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              irq_fire;
  update_kind_t      update_kind;
  logic [SLOT_W-1:0] slot;
  logic [DATA_W-1:0] bank_value;

  modport source (output valid, irq_fire, update_kind, slot, bank_value, input ready);
  modport sink (input valid, irq_fire, update_kind, slot, bank_value, output ready);
endinterface

// ----- rtl/cartridge_bank_irq_mapper.sv -----
// An accepted request is registered first in the input stage and then in the result stage.
// Throughput: one request per cycle while results are taken; the input register and the
// result register form a two-stage pipeline, and each stage advances whenever the stage
// after it frees up. Reset (synchronous, active high) empties both stages and clears the
// counter enable, the scanline counter and the reload latch.
module cartridge_bank_irq_mapper import cbim_pkg::*; #(
  parameter int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF
) (
  input logic       clk,
  input logic       rst,
  cbim_req_if.sink  req,
  cbim_rsp_if.source rsp
);

  localparam logic [LINE_W-1:0] VIS_LIMIT = LINE_W'(VISIBLE_LINES);

  // Input stage
  logic              s1_valid;
  logic              s1_kind;
  logic [ADDR_W-1:0] s1_address;
  logic [DATA_W-1:0] s1_write_data;
  logic [LINE_W-1:0] s1_line_number;
  logic              s1_rendering_on;

  // Result stage
  logic              o_valid;
  logic              o_irq_fire;
  update_kind_t      o_update_kind;
  logic [SLOT_W-1:0] o_slot;
  logic [DATA_W-1:0] o_bank_value;

  // Mapper state
  logic               count_enable;
  logic               count_enable_next;
  logic [COUNT_W-1:0] line_counter;
  logic [COUNT_W-1:0] line_counter_next;
  logic [COUNT_W-1:0] reload_value;
  logic [COUNT_W-1:0] reload_value_next;

  // Result of the request in the input stage
  logic              res_irq_fire;
  update_kind_t      res_update_kind;
  logic [SLOT_W-1:0] res_slot;
  logic [DATA_W-1:0] res_bank_value;
  mirror_t           res_mirror;

  logic out_adv;
  logic s1_adv;

  // Advance each stage when the next one is empty or draining
  assign out_adv   = !o_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_adv;
  assign req.ready = !s1_valid || out_adv;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_kind         <= req.kind;
      s1_address      <= req.address;
      s1_write_data   <= req.write_data;
      s1_line_number  <= req.line_number;
      s1_rendering_on <= req.rendering_on;
    end
  end

  // Decode the request and work out the next state
  always_comb begin
    count_enable_next = count_enable;
    line_counter_next = line_counter;
    reload_value_next = reload_value;
    res_irq_fire      = 1'b0;
    res_update_kind   = UPD_NONE;
    res_slot          = '0;
    res_bank_value    = '0;
    res_mirror        = MIR_SINGLE_A;
    if (s1_kind == KIND_WRITE) begin
      case (s1_address)
        ADR_MIRROR_SINGLE: begin
          res_mirror      = s1_write_data[MIRROR_BIT_POS] ? MIR_SINGLE_B : MIR_SINGLE_A;
          res_update_kind = UPD_MIRROR;
          res_bank_value  = DATA_W'(res_mirror);
        end
        ADR_MIRROR_VH: begin
          res_mirror      = s1_write_data[MIRROR_BIT_POS] ? MIR_HORIZONTAL : MIR_VERTICAL;
          res_update_kind = UPD_MIRROR;
          res_bank_value  = DATA_W'(res_mirror);
        end
        ADR_IRQ_OFF: begin
          count_enable_next = 1'b0;
        end
        ADR_LATCH_LO: begin
          reload_value_next = {reload_value[COUNT_W-1:DATA_W], s1_write_data};
        end
        ADR_LATCH_HI: begin
          reload_value_next = {s1_write_data, reload_value[DATA_W-1:0]};
          line_counter_next = {s1_write_data, reload_value[DATA_W-1:0]};
          count_enable_next = 1'b1;
        end
        default: begin
          if (s1_address inside {[ADR_PRG_BASE:ADR_PRG_LAST]}) begin
            res_update_kind = UPD_PRG;
            res_slot        = SLOT_W'(s1_address - ADR_PRG_BASE);
            res_bank_value  = s1_write_data;
          end else if (s1_address inside {[ADR_CHR_BASE:ADR_CHR_LAST]}) begin
            res_update_kind = UPD_CHR;
            res_slot        = SLOT_W'(s1_address - ADR_CHR_BASE);
            res_bank_value  = s1_write_data;
          end
        end
      endcase
    end else if ((s1_line_number < VIS_LIMIT) && s1_rendering_on && count_enable) begin
      // Fire and stop once the counter is near the top, else step it
      if (line_counter >= FIRE_LEVEL) begin
        res_irq_fire      = 1'b1;
        line_counter_next = '0;
        count_enable_next = 1'b0;
      end else begin
        line_counter_next = line_counter + COUNT_STEP;
      end
    end
  end

  // Commit state as the request leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      count_enable <= 1'b0;
      line_counter <= '0;
      reload_value <= '0;
    end else if (s1_adv) begin
      count_enable <= count_enable_next;
      line_counter <= line_counter_next;
      reload_value <= reload_value_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_adv) begin
      o_valid <= s1_valid;
    end
    if (s1_adv) begin
      o_irq_fire    <= res_irq_fire;
      o_update_kind <= res_update_kind;
      o_slot        <= res_slot;
      o_bank_value  <= res_bank_value;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.irq_fire    = o_irq_fire;
  assign rsp.update_kind = o_update_kind;
  assign rsp.slot        = o_slot;
  assign rsp.bank_value  = o_bank_value;

endmodule

// ----- rtl/cbim_checker.sv -----
`include "cartridge_bank_irq_mapper_defines.svh"

module cbim_checker import cbim_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_irq_fire,
  input update_kind_t      rsp_update_kind,
  input logic [SLOT_W-1:0] rsp_slot,
  input logic [DATA_W-1:0] rsp_bank_value
);

  // No result is shown in the cycle after reset
  `CBIM_ASSERT_RST(a_empty_after_rst, rst |=> !rsp_valid, "result valid after reset")

  // A stalled result holds its payload
  `CBIM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_irq_fire) && $stable(rsp_update_kind) && $stable(rsp_slot) && $stable(rsp_bank_value), "stalled result changed")

  // With the result side empty, a new request is always taken
  `CBIM_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "request blocked with empty output")

  // An accepted request reaches the output through the input and result registers when nothing stalls
  `CBIM_ASSERT(a_latency, (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid, "result missing after two cycles")

  // An interrupt result carries no bank update
  `CBIM_ASSERT(a_irq_clean, rsp_valid && rsp_irq_fire |-> rsp_update_kind == UPD_NONE && rsp_slot == '0 && rsp_bank_value == '0, "interrupt result with update fields")

endmodule

bind cartridge_bank_irq_mapper cbim_checker u_cbim_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_irq_fire    (rsp.irq_fire),
  .rsp_update_kind (rsp.update_kind),
  .rsp_slot        (rsp.slot),
  .rsp_bank_value  (rsp.bank_value)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import cbim_pkg::*;

  localparam int unsigned LINES_SHOWN  = VISIBLE_LINES_DEF;
  localparam int          GAP_MAX      = 17;
  localparam int          SETTLE_WAIT  = 10;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          LONG_HOLD    = 200;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [LINE_W-1:0] line_number;
    logic              rendering_on;
  } map_request_t;

  typedef struct packed {
    logic              irq_fire;
    update_kind_t      update_kind;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] bank_value;
  } map_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbim_req_if req_ch ();
  cbim_rsp_if rsp_ch ();

  cartridge_bank_irq_mapper #(
    .VISIBLE_LINES(VISIBLE_LINES_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Mapper state as the predictor tracks it
  logic               irq_count_on;
  logic [COUNT_W-1:0] scan_count;
  logic [COUNT_W-1:0] reload_latch;

  map_result_t awaited_results[$];
  int          mismatch_count;
  int          requests_sent;
  int          idle_cycles;
  int          req_calm_left;
  int          rsp_calm_left;
  int          rsp_hold_len;
  bit          back_to_back;

  // Predict the result of one request and advance the mapper state
  function automatic map_result_t next_mapper_result(map_request_t r);
    map_result_t res;
    mirror_t     mode;
    res = '{irq_fire: 1'b0, update_kind: UPD_NONE, slot: '0, bank_value: '0};
    if (r.kind == KIND_WRITE) begin
      if (r.address == ADR_MIRROR_SINGLE) begin
        mode = r.write_data[MIRROR_BIT_POS] ? MIR_SINGLE_B : MIR_SINGLE_A;
        res.update_kind = UPD_MIRROR;
        res.bank_value = DATA_W'(mode);
      end else if (r.address == ADR_MIRROR_VH) begin
        mode = r.write_data[MIRROR_BIT_POS] ? MIR_HORIZONTAL : MIR_VERTICAL;
        res.update_kind = UPD_MIRROR;
        res.bank_value = DATA_W'(mode);
      end else if (r.address == ADR_IRQ_OFF) begin
        irq_count_on = 1'b0;
      end else if (r.address == ADR_LATCH_LO) begin
        reload_latch[7:0] = r.write_data;
      end else if (r.address == ADR_LATCH_HI) begin
        reload_latch[15:8] = r.write_data;
        scan_count = reload_latch;
        irq_count_on = 1'b1;
      end else if (r.address >= ADR_PRG_BASE && r.address <= ADR_PRG_LAST) begin
        res.update_kind = UPD_PRG;
        res.slot = SLOT_W'(r.address - ADR_PRG_BASE);
        res.bank_value = r.write_data;
      end else if (r.address >= ADR_CHR_BASE && r.address <= ADR_CHR_LAST) begin
        res.update_kind = UPD_CHR;
        res.slot = SLOT_W'(r.address - ADR_CHR_BASE);
        res.bank_value = r.write_data;
      end
    end else if (int'(r.line_number) < LINES_SHOWN && r.rendering_on && irq_count_on) begin
      if (scan_count >= FIRE_LEVEL) begin
        res.irq_fire = 1'b1;
        scan_count = '0;
        irq_count_on = 1'b0;
      end else begin
        scan_count = scan_count + COUNT_STEP;
      end
    end
    return res;
  endfunction

  // CPU write with don't-care tick fields randomized
  function automatic map_request_t cpu_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    map_request_t r;
    r.kind = KIND_WRITE;
    r.address = addr;
    r.write_data = data;
    r.line_number = LINE_W'($urandom);
    r.rendering_on = 1'($urandom);
    return r;
  endfunction

  // Scanline tick with don't-care write fields randomized
  function automatic map_request_t scan_tick(logic [LINE_W-1:0] line, logic render);
    map_request_t r;
    r.kind = KIND_TICK;
    r.address = ADDR_W'($urandom);
    r.write_data = DATA_W'($urandom);
    r.line_number = line;
    r.rendering_on = render;
    return r;
  endfunction

  // Draw a wait, with occasional runs of zero waits
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
  endtask

  // Offer one request and record its expected result on acceptance
  task automatic send_request(map_request_t r);
    int gap;
    gap = back_to_back ? 0 : draw_wait(req_calm_left);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.kind = r.kind;
    req_ch.address = r.address;
    req_ch.write_data = r.write_data;
    req_ch.line_number = r.line_number;
    req_ch.rendering_on = r.rendering_on;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    awaited_results.push_back(next_mapper_result(r));
    requests_sent++;
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Result side: stall at random, then check each accepted result
  initial begin
    int          stall;
    map_result_t want;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (rsp_hold_len > 0) begin
        stall = rsp_hold_len;
        rsp_hold_len = 0;
      end else begin
        stall = draw_wait(rsp_calm_left);
      end
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", rsp_ch.bank_value, '0);
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.irq_fire !== want.irq_fire)
          report_mismatch("irq_fire", rsp_ch.irq_fire, want.irq_fire);
        if (rsp_ch.update_kind !== want.update_kind)
          report_mismatch("update_kind", rsp_ch.update_kind, want.update_kind);
        if (rsp_ch.slot !== want.slot)
          report_mismatch("slot", rsp_ch.slot, want.slot);
        if (rsp_ch.bank_value !== want.bank_value)
          report_mismatch("bank_value", rsp_ch.bank_value, want.bank_value);
      end
    end
  end

  // Watchdog: end the run when no handshake completes for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Bank and mirroring writes at the field extremes
  task automatic test_bank_writes();
    send_request(cpu_write(ADR_PRG_BASE, 8'h00));
    send_request(cpu_write(ADR_PRG_LAST, 8'hFF));
    send_request(cpu_write(ADR_CHR_BASE, 8'hFF));
    send_request(cpu_write(ADR_CHR_LAST, 8'h00));
    send_request(cpu_write(ADR_MIRROR_SINGLE, 8'hEF));
    send_request(cpu_write(ADR_MIRROR_SINGLE, 8'h10));
    send_request(cpu_write(ADR_MIRROR_VH, 8'h00));
    send_request(cpu_write(ADR_MIRROR_VH, 8'hFF));
  endtask

  // Counter load, ticks that do not count, firing and disable
  task automatic test_scanline_irq();
    send_request(cpu_write(ADR_LATCH_LO, 8'h8D));
    send_request(cpu_write(ADR_LATCH_HI, 8'hFF));
    send_request(scan_tick(LINE_W'(LINES_SHOWN - 1), 1'b1));
    send_request(scan_tick(LINE_W'(LINES_SHOWN), 1'b1));
    send_request(scan_tick('0, 1'b0));
    send_request(scan_tick('1, 1'b1));
    send_request(scan_tick('0, 1'b1));
    send_request(scan_tick('0, 1'b1));
    send_request(cpu_write(ADR_LATCH_HI, 8'h00));
    send_request(cpu_write(ADR_IRQ_OFF, 8'hFF));
    send_request(scan_tick('0, 1'b1));
  endtask

  // Writes outside the register map
  task automatic test_unlisted_addresses();
    send_request(cpu_write(16'h0000, 8'hFF));
    send_request(cpu_write(16'hFFFF, 8'h00));
    send_request(cpu_write(ADR_IRQ_OFF - 16'd1, 8'h5A));
    send_request(cpu_write(ADR_CHR_LAST + 16'd1, 8'hA5));
  endtask

  // Mostly well-formed mapper traffic with some noise
  task automatic test_random_traffic(int count);
    int stop_at;
    int pick;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_request(cpu_write(ADR_PRG_BASE + ADDR_W'($urandom_range(0, 3)), DATA_W'($urandom)));
      end else if (pick < 22) begin
        send_request(cpu_write(ADR_CHR_BASE + ADDR_W'($urandom_range(0, 7)), DATA_W'($urandom)));
      end else if (pick < 28) begin
        send_request(cpu_write($urandom_range(0, 1) ? ADR_MIRROR_VH : ADR_MIRROR_SINGLE,
                               DATA_W'($urandom)));
      end else if (pick < 36) begin
        // Program the counter, usually close to the firing level
        send_request(cpu_write(ADR_LATCH_LO, DATA_W'($urandom)));
        send_request(cpu_write(ADR_LATCH_HI,
                               $urandom_range(0, 3) != 0 ? DATA_W'($urandom_range(8'hF0, 8'hFF))
                                                         : DATA_W'($urandom)));
      end else if (pick < 39) begin
        send_request(cpu_write(ADR_IRQ_OFF, DATA_W'($urandom)));
      end else if (pick < 46) begin
        send_request(cpu_write(ADDR_W'($urandom), DATA_W'($urandom)));
      end else if (pick < 90) begin
        send_request(scan_tick(LINE_W'($urandom_range(0, LINES_SHOWN - 1)), 1'b1));
      end else begin
        send_request(scan_tick(LINE_W'($urandom), 1'($urandom)));
      end
    end
  endtask

  // Hold off results while requests keep coming back to back
  task automatic test_backpressure();
    rsp_hold_len = LONG_HOLD;
    back_to_back = 1'b1;
    test_random_traffic(40);
    back_to_back = 1'b0;
  endtask

  initial begin
    irq_count_on = 1'b0;
    scan_count = '0;
    reload_latch = '0;
    mismatch_count = 0;
    requests_sent = 0;
    idle_cycles = 0;
    req_calm_left = 0;
    rsp_calm_left = 0;
    rsp_hold_len = 0;
    back_to_back = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_WRITE;
    req_ch.address = '0;
    req_ch.write_data = '0;
    req_ch.line_number = '0;
    req_ch.rendering_on = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_bank_writes();
    test_scanline_irq();
    test_unlisted_addresses();
    wait_for_results();
    test_random_traffic(550);
    wait_for_results();
    test_backpressure();
    wait_for_results();
    test_random_traffic(550);
    wait_for_results();
    test_random_traffic(500);
    wait_for_results();

    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cbim_pkg.sv
rtl/cbim_if.sv
rtl/cartridge_bank_irq_mapper.sv
rtl/cbim_checker.sv
tb/testbench.sv
